/* design/rgb2hsv_pkg.sv */
package rgb2hsv_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int FRAC_BITS    = 12;
  localparam int HUE_BITS     = FRAC_BITS + 3;
  localparam int SAT_BITS     = FRAC_BITS + 1;
  // front stage, one stage per quotient bit, output register
  localparam int PIPE_STAGES  = FRAC_BITS + 2;
  localparam int LATENCY      = FRAC_BITS + 3;

  localparam logic [HUE_BITS-1:0] HUE_TWO  = HUE_BITS'(2 << FRAC_BITS);
  localparam logic [HUE_BITS-1:0] HUE_FOUR = HUE_BITS'(4 << FRAC_BITS);
  localparam logic [HUE_BITS-1:0] HUE_SIX  = HUE_BITS'(6 << FRAC_BITS);
  localparam logic [SAT_BITS-1:0] SAT_ONE  = SAT_BITS'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } hsv_in_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [SAT_BITS-1:0]     saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } hsv_out_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] rem_hue;
    logic [CHANNEL_BITS-1:0] rem_sat;
    logic [FRAC_BITS:0]      quo_hue;
    logic [FRAC_BITS:0]      quo_sat;
    logic [CHANNEL_BITS-1:0] chroma;
    logic [CHANNEL_BITS-1:0] bright;
    sector_t                 sector;
    logic                    neg;
  } pipe_t;

endpackage

/* design/rgb_to_hsv_pixel.sv */
// Hexcone RGB to HSV, one pixel word per clock. A word is taken whenever start
// is high; busy is tied low since the pipeline never stalls. Each result shows
// on out_word for exactly one cycle with out_valid high, in input order; the
// receiver must take it then. The depth comes from the two restoring dividers
// (hue difference over chroma, chroma over value), which resolve one quotient
// bit per register stage, behind one max/min stage and ahead of one stage that
// adds the sextant base and registers the result.
module rgb_to_hsv_pixel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rgb2hsv_pkg::hsv_in_t  in_word,
  output logic                  out_valid,
  output rgb2hsv_pkg::hsv_out_t out_word
);
  import rgb2hsv_pkg::*;

  logic                    accept;
  logic [CHANNEL_BITS-1:0] max_c;
  logic [CHANNEL_BITS-1:0] min_c;
  logic [CHANNEL_BITS-1:0] p_c;
  logic [CHANNEL_BITS-1:0] q_c;
  sector_t                 sector_c;

  pipe_t                   stage_r   [0:PIPE_STAGES-1];
  pipe_t                   stage_nxt [0:PIPE_STAGES-1];
  logic [PIPE_STAGES-1:0]  valid_r;

  logic [HUE_BITS-1:0]     base_c;
  logic [HUE_BITS-1:0]     quo_ext_c;
  logic [HUE_BITS-1:0]     hue_c;
  hsv_out_t                out_word_r;
  hsv_out_t                out_word_nxt;
  logic                    out_valid_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // front stage: value, chroma, sector and the signed hue difference
  always_comb begin
    max_c = in_word.red;
    if (in_word.green > max_c) max_c = in_word.green;
    if (in_word.blue > max_c)  max_c = in_word.blue;
    min_c = in_word.red;
    if (in_word.green < min_c) min_c = in_word.green;
    if (in_word.blue < min_c)  min_c = in_word.blue;

    if (max_c == in_word.red) begin
      sector_c = SEC_RED;
      p_c      = in_word.green;
      q_c      = in_word.blue;
    end else if (max_c == in_word.green) begin
      sector_c = SEC_GREEN;
      p_c      = in_word.blue;
      q_c      = in_word.red;
    end else begin
      sector_c = SEC_BLUE;
      p_c      = in_word.red;
      q_c      = in_word.green;
    end

    stage_nxt[0].neg     = p_c < q_c;
    stage_nxt[0].rem_hue = (p_c < q_c) ? (q_c - p_c) : (p_c - q_c);
    stage_nxt[0].chroma  = max_c - min_c;
    stage_nxt[0].rem_sat = max_c - min_c;
    stage_nxt[0].bright  = max_c;
    stage_nxt[0].sector  = sector_c;
    stage_nxt[0].quo_hue = '0;
    stage_nxt[0].quo_sat = '0;
  end

  // divider stages: the first resolves the integer bit, the rest one
  // fraction bit each; remainders stay below a nonzero divisor
  for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_div
    logic [CHANNEL_BITS:0] num_hue;
    logic [CHANNEL_BITS:0] num_sat;
    logic [CHANNEL_BITS:0] dif_hue;
    logic [CHANNEL_BITS:0] dif_sat;
    logic                  bit_hue;
    logic                  bit_sat;

    if (k == 0) begin : g_int
      assign num_hue = {1'b0, stage_r[k].rem_hue};
      assign num_sat = {1'b0, stage_r[k].rem_sat};
    end else begin : g_frac
      assign num_hue = {stage_r[k].rem_hue, 1'b0};
      assign num_sat = {stage_r[k].rem_sat, 1'b0};
    end

    assign dif_hue = num_hue - {1'b0, stage_r[k].chroma};
    assign dif_sat = num_sat - {1'b0, stage_r[k].bright};
    assign bit_hue = num_hue >= {1'b0, stage_r[k].chroma};
    assign bit_sat = num_sat >= {1'b0, stage_r[k].bright};

    always_comb begin
      stage_nxt[k+1]         = stage_r[k];
      stage_nxt[k+1].rem_hue = bit_hue ? dif_hue[CHANNEL_BITS-1:0]
                                       : num_hue[CHANNEL_BITS-1:0];
      stage_nxt[k+1].rem_sat = bit_sat ? dif_sat[CHANNEL_BITS-1:0]
                                       : num_sat[CHANNEL_BITS-1:0];
      stage_nxt[k+1].quo_hue = {stage_r[k].quo_hue[FRAC_BITS-1:0], bit_hue};
      stage_nxt[k+1].quo_sat = {stage_r[k].quo_sat[FRAC_BITS-1:0], bit_sat};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PIPE_STAGES; i++) begin
      stage_r[i] <= stage_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r[0] <= accept;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  // output stage: add the sextant base, wrap six to zero, zero hue and saturation for grey pixels
  always_comb begin
    case (stage_r[PIPE_STAGES-1].sector)
      SEC_RED:   base_c = stage_r[PIPE_STAGES-1].neg ? HUE_SIX : '0;
      SEC_GREEN: base_c = HUE_TWO;
      SEC_BLUE:  base_c = HUE_FOUR;
      default:   base_c = '0;
    endcase
    quo_ext_c = {2'b00, stage_r[PIPE_STAGES-1].quo_hue};
    hue_c     = stage_r[PIPE_STAGES-1].neg ? (base_c - quo_ext_c) : (base_c + quo_ext_c);

    out_word_nxt.brightness = stage_r[PIPE_STAGES-1].bright;
    if (stage_r[PIPE_STAGES-1].chroma == '0) begin
      out_word_nxt.hue        = '0;
      out_word_nxt.saturation = '0;
    end else begin
      out_word_nxt.hue        = (hue_c >= HUE_SIX) ? '0 : hue_c;
      out_word_nxt.saturation = stage_r[PIPE_STAGES-1].quo_sat;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_r[PIPE_STAGES-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result word without a matching start");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.saturation <= SAT_ONE)
    else $error("saturation above one");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.hue < HUE_SIX)
    else $error("hue not below six");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[PIPE_STAGES-1] && stage_r[PIPE_STAGES-1].chroma != '0) |->
      (stage_r[PIPE_STAGES-1].rem_hue < stage_r[PIPE_STAGES-1].chroma &&
       stage_r[PIPE_STAGES-1].rem_sat < stage_r[PIPE_STAGES-1].bright))
    else $error("divider remainder not below divisor");
`endif

endmodule

/* tb/rgb_to_hsv_pixel_test.sv */
module rgb_to_hsv_pixel_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb2hsv_pkg::*;

  localparam int RANDOM_PIXELS = 1150;
  localparam int PHASES        = 4;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  logic     busy;
  hsv_in_t  in_word = '0;
  logic     out_valid;
  hsv_out_t out_word;

  hsv_in_t  pixel_q[$];
  hsv_out_t hsv_q[$];
  int       idle_pct       = 0;
  int       fail_count     = 0;
  int       mismatch_count = 0;

  rgb_to_hsv_pixel uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always #10 clk = ~clk;

  // Hexcone conversion, truncating quotients toward zero.
  function automatic hsv_out_t hsv_from_rgb(hsv_in_t px);
    longint   r, g, b, mx, mn, c, diff, quo, base, h;
    hsv_out_t res;
    r  = px.red;
    g  = px.green;
    b  = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    res.brightness = mx[CHANNEL_BITS-1:0];
    res.hue        = '0;
    res.saturation = '0;
    if (c > 0) begin
      if (mx == r) begin
        base = 0;
        diff = g - b;
      end else if (mx == g) begin
        base = 2;
        diff = b - r;
      end else begin
        base = 4;
        diff = r - g;
      end
      quo = ((diff < 0 ? -diff : diff) << FRAC_BITS) / c;
      h = (base << FRAC_BITS) + (diff < 0 ? -quo : quo);
      if (base == 0 && g < b) h += longint'(6) << FRAC_BITS;
      if (h < 0 || h >= (longint'(6) << FRAC_BITS)) h = 0;
      res.hue        = h[HUE_BITS-1:0];
      res.saturation = SAT_BITS'((c << FRAC_BITS) / mx);
    end
    return res;
  endfunction

  function automatic hsv_in_t rgb(int r, int g, int b);
    hsv_in_t px;
    px.red   = CHANNEL_BITS'(r);
    px.green = CHANNEL_BITS'(g);
    px.blue  = CHANNEL_BITS'(b);
    return px;
  endfunction

  // Mostly uniform pixels, with greys, tied maxima, low-chroma and fully saturated pixels mixed in.
  function automatic hsv_in_t random_pixel();
    int kind, hi, lo, pick;
    kind = $urandom_range(9);
    hi   = $urandom_range(255);
    lo   = $urandom_range(hi);
    pick = $urandom_range(2);
    case (kind)
      6: return rgb(hi, hi, hi);
      7: begin
        if (pick == 0) return rgb(hi, hi, lo);
        else if (pick == 1) return rgb(lo, hi, hi);
        else return rgb(hi, lo, hi);
      end
      8: begin
        lo = $urandom_range(252);
        return rgb(lo + $urandom_range(3), lo + $urandom_range(3), lo + $urandom_range(3));
      end
      9: begin
        if (pick == 0) return rgb(255, 0, $urandom_range(255));
        else if (pick == 1) return rgb($urandom_range(255), 255, 0);
        else return rgb(0, $urandom_range(255), 255);
      end
      default: return rgb($urandom_range(255), $urandom_range(255), $urandom_range(255));
    endcase
  endfunction

  // Driver: log the word taken at this edge, then present the next one or idle.
  always @(posedge clk) begin
    hsv_in_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) hsv_q.push_back(hsv_from_rgb(in_word));
      if (start && busy) begin
        // hold the current word
      end else if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pixel_q.pop_front();
        in_word <= nxt;
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    hsv_out_t want;
    if (rst_n && out_valid) begin
      if (hsv_q.size() == 0) begin
        fail_count++;
        $display("unexpected result: hue %0d sat %0d val %0d",
                 out_word.hue, out_word.saturation, out_word.brightness);
      end else begin
        want = hsv_q.pop_front();
        if (out_word.hue !== want.hue || out_word.saturation !== want.saturation ||
            out_word.brightness !== want.brightness) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
                     want.hue, want.saturation, want.brightness,
                     out_word.hue, out_word.saturation, out_word.brightness);
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, every sector, ties and greys
    pixel_q.push_back(rgb(0, 0, 0));
    pixel_q.push_back(rgb(255, 255, 255));
    pixel_q.push_back(rgb(77, 77, 77));
    pixel_q.push_back(rgb(255, 0, 0));
    pixel_q.push_back(rgb(0, 255, 0));
    pixel_q.push_back(rgb(0, 0, 255));
    pixel_q.push_back(rgb(255, 255, 0));
    pixel_q.push_back(rgb(0, 255, 255));
    pixel_q.push_back(rgb(255, 0, 255));
    pixel_q.push_back(rgb(1, 0, 1));
    pixel_q.push_back(rgb(255, 0, 1));
    pixel_q.push_back(rgb(254, 0, 255));
    pixel_q.push_back(rgb(1, 0, 0));
    pixel_q.push_back(rgb(255, 254, 254));
    pixel_q.push_back(rgb(10, 20, 30));
    pixel_q.push_back(rgb(255, 128, 0));
    pixel_q.push_back(rgb(0, 128, 255));
    pixel_q.push_back(rgb(128, 255, 127));
    pixel_q.push_back(rgb(170, 85, 255));
    pixel_q.push_back(rgb(200, 100, 150));
    wait (pixel_q.size() == 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1:       idle_pct = 59;
        2:       idle_pct = 20;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < RANDOM_PIXELS / PHASES; i++) pixel_q.push_back(random_pixel());
      wait (pixel_q.size() == 0);
    end

    @(posedge clk);
    wait (!start);
    wait (hsv_q.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    if (hsv_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
